// ===== rtl/abpb_pkg.sv =====
package abpb_pkg;

	localparam int MAX_BOXES_DEF   = 64;
	localparam int FILTER_BITS_DEF = 16;
	localparam int COORD_W         = 32;
	localparam int GROUP_W         = 16;
	localparam int INDEX_W         = 6;
	localparam int MARGIN_W        = 16;
	localparam int PADDR_W         = 2;
	localparam int PDATA_W         = 32;

	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd6554;
	localparam logic [PADDR_W-1:0]  REG_MARGIN   = 2'd0;

	// One input request, first member in the most significant bits.
	typedef struct packed {
		logic                      start_frame;
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_z;
		logic [GROUP_W-1:0]        group_bits;
		logic [GROUP_W-1:0]        mask_bits;
		logic                      fixed_body;
	} abpb_req_t;

	typedef struct packed {
		logic [INDEX_W-1:0] earlier_index;
		logic [INDEX_W-1:0] new_index;
		logic               hit;
		logic               overflow;
		logic               last;
	} abpb_res_t;

	// One stored box, with group and mask already reduced to the filter width.
	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_z;
		logic [GROUP_W-1:0]        group;
		logic [GROUP_W-1:0]        mask;
		logic                      fixed;
	} abpb_box_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} abpb_state_t;

endpackage

// ===== rtl/abpb_box_mem.sv =====
module abpb_box_mem #(
	parameter int DEPTH  = abpb_pkg::MAX_BOXES_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  abpb_pkg::abpb_box_t wr_data,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	output abpb_pkg::abpb_box_t rd_data_s1
);

	abpb_pkg::abpb_box_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data holds while rd_en is low, so a stalled compare keeps its operand.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/abpb_pair_test.sv =====
module abpb_pair_test (
	input  abpb_pkg::abpb_box_t               stored,
	input  abpb_pkg::abpb_box_t               incoming,
	input  logic [abpb_pkg::MARGIN_W-1:0]     margin,
	output logic                              hit
);

	localparam int DW = abpb_pkg::COORD_W + 2;

	logic [abpb_pkg::MARGIN_W:0] margin2;
	logic                        filter_ok;
	logic                        ov_x;
	logic                        ov_y;
	logic                        ov_z;

	// Both boxes grown by m overlap when each min minus the other max is at most 2m.
	function automatic logic axis_ok(
		input logic signed [abpb_pkg::COORD_W-1:0] amin,
		input logic signed [abpb_pkg::COORD_W-1:0] amax,
		input logic signed [abpb_pkg::COORD_W-1:0] bmin,
		input logic signed [abpb_pkg::COORD_W-1:0] bmax,
		input logic [abpb_pkg::MARGIN_W:0]         m2
	);
		logic signed [DW-1:0] d1;
		logic signed [DW-1:0] d2;
		logic signed [DW-1:0] lim;
		d1  = DW'(amin) - DW'(bmax);
		d2  = DW'(bmin) - DW'(amax);
		lim = $signed(DW'(m2));
		return (d1 <= lim) && (d2 <= lim);
	endfunction

	assign margin2   = {margin, 1'b0};
	assign filter_ok = !(stored.fixed && incoming.fixed)
	                   && (|(stored.group & incoming.mask))
	                   && (|(incoming.group & stored.mask));
	assign ov_x = axis_ok(stored.min_x, stored.max_x, incoming.min_x, incoming.max_x, margin2);
	assign ov_y = axis_ok(stored.min_y, stored.max_y, incoming.min_y, incoming.max_y, margin2);
	assign ov_z = axis_ok(stored.min_z, stored.max_z, incoming.min_z, incoming.max_z, margin2);
	assign hit  = filter_ok && ov_x && ov_y && ov_z;

endmodule

// ===== rtl/aabb_pair_broadphase_top.sv =====
// A box is accepted only while the sequencer is idle, so the next box waits until the final
// result of this one has been pushed; no scan is made when the store is empty or full.
// The box store has one read port and one pair test unit, which take one stored entry per
// cycle unless a blocked output freezes the scan.
// Reset clears the box count, the sequencer and the output register and sets margin to 6554;
// the box store itself is not cleared, since only entries written in the current frame are read.
module aabb_pair_broadphase_top #(
	parameter int MAX_BOXES   = abpb_pkg::MAX_BOXES_DEF,
	parameter int FILTER_BITS = abpb_pkg::FILTER_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Request channel: one box per request.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  abpb_pkg::abpb_req_t           in_req,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output abpb_pkg::abpb_res_t           out_res,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [abpb_pkg::PADDR_W-1:0]  paddr,
	input  logic [abpb_pkg::PDATA_W-1:0]  pwdata,
	output logic [abpb_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	localparam int ADDR_W = $clog2(MAX_BOXES);
	localparam int CNT_W  = $clog2(MAX_BOXES + 1);
	localparam int IW     = abpb_pkg::INDEX_W;
	localparam int GW     = abpb_pkg::GROUP_W;
	localparam int MW     = abpb_pkg::MARGIN_W;
	localparam int DW     = abpb_pkg::PDATA_W;
	localparam logic [GW-1:0] FILT_MASK =
		(FILTER_BITS >= GW) ? {GW{1'b1}} : GW'((33'd1 << FILTER_BITS) - 33'd1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BOXES);

	// Configuration register.
	logic [MW-1:0] margin_q;
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == abpb_pkg::REG_MARGIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= abpb_pkg::MARGIN_RESET;
		end else if (cfg_wr) begin
			margin_q <= pwdata[MW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == abpb_pkg::REG_MARGIN) begin
			prdata = DW'(margin_q);
		end
	end

	// Sequencer state and per-request registers.
	abpb_pkg::abpb_state_t state_q, state_d;
	logic [CNT_W-1:0]      count_q;
	logic [ADDR_W-1:0]     new_idx_q;
	logic                  ovf_q;
	abpb_pkg::abpb_box_t   newbox_q;
	logic [ADDR_W-1:0]     rd_addr_q;
	logic                  issue_done_q;
	logic                  v_s1;
	logic [ADDR_W-1:0]     idx_s1;
	logic                  pend_valid_q;
	logic [ADDR_W-1:0]     pend_idx_q;
	logic                  out_valid_q;
	abpb_pkg::abpb_res_t   out_q;

	// Request acceptance and the store write of the incoming box.
	logic                  accept;
	logic [CNT_W-1:0]      cnt_eff;
	logic                  full;
	abpb_pkg::abpb_box_t   in_box;

	assign in_stall = (state_q != abpb_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign cnt_eff  = in_req.start_frame ? '0 : count_q;
	assign full     = (cnt_eff == CNT_FULL);

	always_comb begin
		in_box.min_x = in_req.min_x;
		in_box.min_y = in_req.min_y;
		in_box.min_z = in_req.min_z;
		in_box.max_x = in_req.max_x;
		in_box.max_y = in_req.max_y;
		in_box.max_z = in_req.max_z;
		in_box.group = in_req.group_bits & FILT_MASK;
		in_box.mask  = in_req.mask_bits & FILT_MASK;
		in_box.fixed = in_req.fixed_body;
	end

	// The scan reads one stored entry per cycle while not frozen and feeds the pair test the cycle after.
	abpb_pkg::abpb_box_t rd_data_s1;
	logic                pair_hit;
	logic                cmp_hit;
	logic                out_free;
	logic                hold;
	logic                issue_en;
	logic                last_issue;
	logic                scan_push;
	logic                flush_push;
	abpb_pkg::abpb_res_t push_res;

	abpb_box_mem #(
		.DEPTH  (MAX_BOXES),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk        (clk),
		.wr_en      (accept && !full),
		.wr_addr    (cnt_eff[ADDR_W-1:0]),
		.wr_data    (in_box),
		.rd_en      (issue_en),
		.rd_addr    (rd_addr_q),
		.rd_data_s1 (rd_data_s1)
	);

	abpb_pair_test u_pair (
		.stored   (rd_data_s1),
		.incoming (newbox_q),
		.margin   (margin_q),
		.hit      (pair_hit)
	);

	// A hit is held back in the pending register until the next hit or the end of the scan,
	// so that the last flag can be set on the final one. A new hit while the pending one
	// cannot move to the output freezes the scan.
	assign out_free   = !out_valid_q || !out_stall;
	assign cmp_hit    = v_s1 && pair_hit;
	assign hold       = cmp_hit && pend_valid_q && !out_free;
	assign last_issue = (rd_addr_q == ADDR_W'(new_idx_q - 1'b1));
	assign scan_push  = cmp_hit && pend_valid_q && !hold;

	always_comb begin
		state_d    = state_q;
		issue_en   = 1'b0;
		flush_push = 1'b0;
		push_res   = '0;
		unique case (state_q)
			abpb_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (full || (cnt_eff == '0)) ? abpb_pkg::ST_FLUSH : abpb_pkg::ST_SCAN;
				end
			end
			abpb_pkg::ST_SCAN: begin
				issue_en = !issue_done_q && !hold;
				if (issue_done_q && !v_s1) begin
					state_d = abpb_pkg::ST_FLUSH;
				end
				push_res.earlier_index = IW'(pend_idx_q);
				push_res.new_index     = IW'(new_idx_q);
				push_res.hit           = 1'b1;
			end
			abpb_pkg::ST_FLUSH: begin
				flush_push = out_free;
				if (out_free) begin
					state_d = abpb_pkg::ST_IDLE;
				end
				push_res.last = 1'b1;
				if (ovf_q) begin
					push_res.overflow = 1'b1;
				end else if (pend_valid_q) begin
					push_res.earlier_index = IW'(pend_idx_q);
					push_res.new_index     = IW'(new_idx_q);
					push_res.hit           = 1'b1;
				end else begin
					push_res.new_index = IW'(new_idx_q);
				end
			end
			default: begin
				state_d = abpb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= abpb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			ovf_q        <= 1'b0;
			issue_done_q <= 1'b0;
			v_s1         <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				ovf_q        <= full;
				issue_done_q <= 1'b0;
				pend_valid_q <= 1'b0;
				count_q      <= full ? cnt_eff : cnt_eff + 1'b1;
			end else begin
				if (issue_en && last_issue) begin
					issue_done_q <= 1'b1;
				end
				if (cmp_hit && !hold) begin
					pend_valid_q <= 1'b1;
				end
			end
			if (!hold) begin
				v_s1 <= issue_en;
			end
			if (scan_push || flush_push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			newbox_q  <= in_box;
			new_idx_q <= full ? '0 : cnt_eff[ADDR_W-1:0];
			rd_addr_q <= '0;
		end else if (issue_en) begin
			rd_addr_q <= rd_addr_q + 1'b1;
		end
		if (issue_en) begin
			idx_s1 <= rd_addr_q;
		end
		if (cmp_hit && !hold) begin
			pend_idx_q <= idx_s1;
		end
		if (scan_push || flush_push) begin
			out_q <= push_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// The box count never runs past the store's capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("box count exceeds capacity");

	// A reported pair always names an earlier box below the incoming one.
	a_hit_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_res.hit |-> out_res.earlier_index < out_res.new_index)
		else $error("hit pair out of order");

	// A refused box gives exactly one result, with no hit.
	a_ovf_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_res.overflow |-> !out_res.hit && out_res.last)
		else $error("overflow result malformed");

	// The scan only freezes while a pending hit waits on a blocked output.
	a_hold_cause: assert property (@(posedge clk) disable iff (!arst_n)
		hold |-> pend_valid_q && out_valid_q && (state_q == abpb_pkg::ST_SCAN))
		else $error("scan held without cause");

	// A pushed scan result never carries the last flag; it is set only when the scan ends.
	a_scan_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		scan_push |=> out_valid && out_res.hit && !out_res.last)
		else $error("scan result marked last");

endmodule
